// ----- design/ssp_pkg.sv -----
// Shared types and constants for the stream statistics prime counter.
package ssp_pkg;

  localparam int unsigned CountW = 17;
  localparam logic [CountW-1:0] CountCap = CountW'(65536);
  localparam logic signed [31:0] IntMin = 32'sh8000_0000;
  localparam logic signed [31:0] IntMax = 32'sh7fff_ffff;

  typedef struct packed {
    logic signed [31:0] element;
    logic               is_last;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] odd_sum;
    logic signed [31:0] even_total;
    logic [CountW-1:0]  odd_tally;
    logic [CountW-1:0]  even_tally;
    logic signed [31:0] square_sum;
    logic signed [31:0] cube_sum;
    logic signed [31:0] largest;
    logic signed [31:0] smallest;
    logic signed [31:0] second_largest;
    logic signed [31:0] second_smallest;
    logic signed [31:0] prime_total;
    logic [CountW-1:0]  prime_tally;
  } out_req_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture input, start transform
    logic mul_sq;     // compute t*t
    logic mul_cube;   // compute sq*t
    logic accum;      // fold t into statistics
    logic div_start;  // start trial-division test
    logic div_step;   // one remainder step
    logic prime_add;  // add t to prime statistics
    logic emit;       // copy statistics to output register, clear
  } ssp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_last;
    logic test_skip;    // t <= 1
    logic small_prime;  // t below 4
    logic div_done;     // remainder ready
    logic div_zero;     // remainder is zero
    logic div_over;     // next divisor squared exceeds t
  } ssp_sts_t;

endpackage

// ----- design/ssp_stream_if.sv -----
// Valid/ready channel carrying one request payload.
interface ssp_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/ssp_datapath.sv -----
// Datapath: transform, statistics registers, serial divider, output register.
module ssp_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic signed [31:0] cfg_gain,
  input  ssp_pkg::in_req_t  req,
  input  ssp_pkg::ssp_cmd_t cmd,
  output ssp_pkg::ssp_sts_t sts,
  output ssp_pkg::out_req_t result
);
  import ssp_pkg::*;

  logic [31:0] t_r, sq_r, cube_r;
  logic        last_r;
  logic [31:0] sum_r;
  logic [31:0] odd_sum_r, even_sum_r, sqs_r, cubes_r, psum_r;
  logic [CountW-1:0] odd_cnt_r, even_cnt_r, pcnt_r;
  logic signed [31:0] max_r, min_r, smax_r, smin_r;
  logic [15:0] d_r;
  logic [31:0] rem_r, quo_r;
  logic [5:0]  bit_r;
  logic        busy_r;
  out_req_t    result_r;
  logic signed [31:0] s;
  logic [32:0] rtry;
  logic [31:0] rsh;
  logic [32:0] dsq_nxt;
  logic [16:0] d1;

  assign s = signed'(t_r);
  assign d1 = {1'b0, d_r} + 17'd1;
  assign dsq_nxt = 33'(d1 * d1);
  assign rsh = {rem_r[30:0], quo_r[31]};
  assign rtry = {1'b0, rsh} - {17'd0, d_r};

  function automatic logic [CountW-1:0] bump(input logic [CountW-1:0] c);
    return (c < CountCap) ? c + CountW'(1) : c;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b0;
    else if (cmd.load) busy_r <= 1'b1;
    else if (busy_r) busy_r <= 1'b0;
    if (cmd.load) begin
      sum_r  <= req.element + cfg_gain;
      last_r <= req.is_last;
    end else if (busy_r) begin
      t_r    <= sum_r * cfg_gain;
    end
    if (cmd.mul_sq) sq_r <= t_r * t_r;
    if (cmd.mul_cube) cube_r <= sq_r * t_r;
    if (cmd.div_start) begin
      d_r   <= 16'd2;
      rem_r <= '0;
      quo_r <= t_r;
      bit_r <= 6'd32;
    end else if (cmd.div_step) begin
      if (bit_r != 6'd0) begin
        rem_r <= rtry[32] ? rsh : rtry[31:0];
        quo_r <= {quo_r[30:0], 1'b0};
        bit_r <= bit_r - 6'd1;
      end else begin
        d_r   <= d1[15:0];
        rem_r <= '0;
        quo_r <= t_r;
        bit_r <= 6'd32;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit) begin
      odd_sum_r <= '0; even_sum_r <= '0; sqs_r <= '0; cubes_r <= '0; psum_r <= '0;
      odd_cnt_r <= '0; even_cnt_r <= '0; pcnt_r <= '0;
      max_r <= IntMin; smax_r <= IntMin; min_r <= IntMax; smin_r <= IntMax;
    end else begin
      if (cmd.accum) begin
        if (t_r[0]) begin
          odd_sum_r <= odd_sum_r + t_r;
          odd_cnt_r <= bump(odd_cnt_r);
        end else begin
          even_sum_r <= even_sum_r + t_r;
          even_cnt_r <= bump(even_cnt_r);
        end
        sqs_r   <= sqs_r + sq_r;
        cubes_r <= cubes_r + cube_r;
        if (s > max_r) begin
          smax_r <= max_r;
          max_r  <= s;
        end else if (s < max_r && s > smax_r) begin
          smax_r <= s;
        end
        if (s < min_r) begin
          smin_r <= min_r;
          min_r  <= s;
        end else if (s > min_r && s < smin_r) begin
          smin_r <= s;
        end
      end
      if (cmd.prime_add) begin
        psum_r <= psum_r + t_r;
        pcnt_r <= bump(pcnt_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result_r.odd_sum         <= odd_sum_r;
      result_r.even_total      <= even_sum_r;
      result_r.odd_tally       <= odd_cnt_r;
      result_r.even_tally      <= even_cnt_r;
      result_r.square_sum      <= sqs_r;
      result_r.cube_sum        <= cubes_r;
      result_r.largest         <= max_r;
      result_r.smallest        <= min_r;
      result_r.second_largest  <= smax_r;
      result_r.second_smallest <= smin_r;
      result_r.prime_total     <= psum_r;
      result_r.prime_tally     <= pcnt_r;
    end
  end

  assign result          = result_r;
  assign sts.is_last     = last_r;
  assign sts.test_skip   = s < 32'sd2;
  assign sts.small_prime = t_r < 32'd4;
  assign sts.div_done    = bit_r == 6'd0;
  assign sts.div_zero    = rem_r == 32'd0;
  assign sts.div_over    = dsq_nxt > {1'b0, t_r};
endmodule

// ----- design/ssp_ctrl.sv -----
// Controller: sequences transform, accumulation, trial division and output.
module ssp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ssp_pkg::ssp_sts_t sts,
  output ssp_pkg::ssp_cmd_t cmd
);
  import ssp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_XFORM = 3'd1;
  localparam logic [2:0] S_SQ    = 3'd2;
  localparam logic [2:0] S_CUBE  = 3'd3;
  localparam logic [2:0] S_ACC   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;
  logic       first_r, first_nxt;

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r && !out_ready;
    first_nxt = first_r;
    cmd       = '0;
    in_ready  = state_r == S_IDLE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_XFORM;
        end
      end
      S_XFORM: state_nxt = S_SQ;
      S_SQ: begin
        cmd.mul_sq = 1'b1;
        state_nxt  = S_CUBE;
      end
      S_CUBE: begin
        cmd.mul_cube = 1'b1;
        state_nxt    = S_ACC;
      end
      S_ACC: begin
        cmd.accum     = 1'b1;
        cmd.div_start = 1'b1;
        first_nxt     = 1'b1;
        if (sts.test_skip) state_nxt = S_FIN;
        else state_nxt = S_DIV;
      end
      S_DIV: begin
        if (first_r) begin
          first_nxt = 1'b0;
          if (sts.small_prime) begin
            cmd.prime_add = 1'b1;
            state_nxt     = S_FIN;
          end else begin
            cmd.div_step = 1'b1;
          end
        end else if (!sts.div_done) begin
          cmd.div_step = 1'b1;
        end else if (sts.div_zero) begin
          state_nxt = S_FIN;
        end else if (sts.div_over) begin
          cmd.prime_add = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_FIN: begin
        if (!sts.is_last) begin
          state_nxt = S_IDLE;
        end else if (!ov_r || out_ready) begin
          cmd.emit  = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      first_r <= first_nxt;
    end
  end

  assign out_valid = ov_r;
endmodule

// ----- design/stream_statistics_prime_count.sv -----
// Top level: stream statistics with trial-division prime counting.
// Timing: t <= 1 skips the prime test, t of 2 or 3 counts as prime at once,
// else trial division by each divisor in turn, plus any pending-result wait.
// Throughput: one request at a time; the serial remainder unit (one bit per
// cycle) sets the rate for large primes.
// Reset: synchronous active-low rst_n clears statistics, gain and control.
module stream_statistics_prime_count (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  ssp_stream_if.sink   in_ch,
  ssp_stream_if.source out_ch
);
  import ssp_pkg::*;

  logic signed [31:0] gain_r;
  ssp_cmd_t cmd;
  ssp_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) gain_r <= '0;
    else if (cfg_we) gain_r <= cfg_wdata;
  end

  ssp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  ssp_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_gain(gain_r),
    .req(in_ch.data), .cmd(cmd), .sts(sts), .result(out_ch.data)
  );
endmodule
